// ===== rtl/crcpf_pkg.sv =====
// crcpf_pkg: shared types, constants and the byte-wide crc-16 update
// for the packet frame checker; no dependencies
package crcpf_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 255;
	localparam int HEADER_BYTES         = 4;
	localparam logic [15:0] CRC_START   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BAD_CRC = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  packet_type;
		logic [7:0]  sequence_number;
		logic [15:0] computed_crc;
	} result_t;

	// reflected crc-16, one byte, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
	                                           input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc16_packet_frame_checker_top.sv =====
// crc16_packet_frame_checker_top: top level of the packet frame checker
// depends on crcpf_pkg, crcpf_frame, crcpf_out_stage
//
// usage
//   slave side: one packet byte per transaction, header byte 0 first;
//   s_tlast marks the final byte of the packet
//   master side: one transaction per packet, sent after its last byte;
//   m_tuser carries the status (ok, too short, crc mismatch), m_tdata the
//   packet type, sequence number and the crc computed over the payload
//   a last byte is captured in the input register, runs through the header/crc
//   logic and lands in the result register that drives m_tvalid
//   throughput: one byte per cycle while no last byte waits behind a held
//   result, set by the byte-wide crc update between the input register
//   and the state/result registers
//   stall: a held result blocks only a pending last byte; non-last bytes
//   keep flowing while the receiver stalls, and s_tready drops once a last
//   byte waits in the input register behind a result not yet taken
//   reset: arst_n clears the input and result valids and returns the packet
//   state to its start (count zero, crc 0xffff)
//   bytes beyond MAX_PACKET_BYTES are ignored until the last byte
module crc16_packet_frame_checker_top #(
	parameter int MAX_PACKET_BYTES = crcpf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] packet_type, [15:8] sequence_number,
	                               // [31:16] computed_crc
	output logic [1:0]  m_tuser    // [1:0] status
);
	import crcpf_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic    out_free;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t res_out;

	// a byte leaves the input register unless it is a last byte and the
	// result register is still occupied
	assign advance  = valid_s1 & (~last_s1 | out_free);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// header capture, crc and status
	crcpf_frame #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	crcpf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_out  (res_out)
	);

	assign m_tuser = res_out.status;
	assign m_tdata = {res_out.computed_crc, res_out.sequence_number, res_out.packet_type};

endmodule

// ===== rtl/crcpf_frame.sv =====
// crcpf_frame: per-packet state, header capture, crc update and status
// depends on crcpf_pkg
module crcpf_frame #(
	parameter int MAX_PACKET_BYTES = crcpf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                res_valid,
	output crcpf_pkg::result_t  res
);
	import crcpf_pkg::*;

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [POS_W-1:0] pos_q,  pos_d;
	logic [15:0]      crc_q,  crc_d;
	logic [7:0]       type_q, type_d;
	logic [7:0]       seq_q,  seq_d;
	logic [15:0]      rcrc_q, rcrc_d;

	always_comb begin
		pos_d  = pos_q;
		crc_d  = crc_q;
		type_d = type_q;
		seq_d  = seq_q;
		rcrc_d = rcrc_q;
		// bytes past the limit are dropped and the count holds
		if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
			case (pos_q)
				POS_W'(0): type_d = data_byte;
				POS_W'(1): seq_d = data_byte;
				POS_W'(2): rcrc_d = {rcrc_q[15:8], data_byte};
				POS_W'(3): rcrc_d = {data_byte, rcrc_q[7:0]};
				default:   crc_d = crc16_byte(crc_q, data_byte);
			endcase
			pos_d = pos_q + POS_W'(1);
		end
	end

	always_comb begin
		if (pos_d < POS_W'(HEADER_BYTES)) begin
			res.status          = ST_SHORT;
			res.packet_type     = '0;
			res.sequence_number = '0;
			res.computed_crc    = '0;
		end else begin
			res.status          = (rcrc_d == crc_d) ? ST_OK : ST_BAD_CRC;
			res.packet_type     = type_d;
			res.sequence_number = seq_d;
			res.computed_crc    = crc_d;
		end
	end

	assign res_valid = advance & last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_START;
			type_q <= '0;
			seq_q  <= '0;
			rcrc_q <= '0;
		end else if (advance) begin
			if (last_byte) begin
				pos_q  <= '0;
				crc_q  <= CRC_START;
				type_q <= '0;
				seq_q  <= '0;
				rcrc_q <= '0;
			end else begin
				pos_q  <= pos_d;
				crc_q  <= crc_d;
				type_q <= type_d;
				seq_q  <= seq_d;
				rcrc_q <= rcrc_d;
			end
		end
	end

endmodule

// ===== rtl/crcpf_out_stage.sv =====
// crcpf_out_stage: result register feeding the master-side stream
// depends on crcpf_pkg
module crcpf_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  crcpf_pkg::result_t  res,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output crcpf_pkg::result_t  res_out
);
	import crcpf_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free     = ~valid_q | m_tready;
	assign m_tvalid = valid_q;
	assign res_out  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/crcpf_checker.sv =====
// crcpf_checker: port-level assertions for the packet frame checker
// depends on crcpf_pkg; bound to crc16_packet_frame_checker_top
module crcpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import crcpf_pkg::*;

	// a stalled result holds its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only defined status codes appear
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SHORT || m_tuser == ST_BAD_CRC))
		else $error("undefined status code");

	// a short packet reports zeroed fields
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_SHORT |-> m_tdata == 32'h0)
		else $error("short packet with nonzero fields");

	// input only stalls behind a result that is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled without a held result");

endmodule

bind crc16_packet_frame_checker_top crcpf_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/tb_crc16_packet_frame_checker_top.sv =====
// tb_crc16_packet_frame_checker_top: self-checking bench for the crc-16 packet frame checker
// tracks header capture and payload crc per accepted byte and checks every report
// depends on crcpf_pkg and crc16_packet_frame_checker_top
`timescale 1ns / 100ps

module tb_crc16_packet_frame_checker_top;

	import crcpf_pkg::*;

	localparam int FRAME_LIMIT = MAX_PACKET_BYTES_DEF;
	localparam int HOLD_LEN    = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] packet_type, [15:8] sequence_number, [31:16] computed_crc
	logic [1:0]  m_tuser;   // [1:0] status

	// reports the checker owes us, oldest first
	result_t     pending_reports[$];
	int          mismatches;

	// bench-side copy of the frame state
	logic [7:0]  seen_count;
	logic [15:0] payload_crc;
	logic [7:0]  held_type;
	logic [7:0]  held_seq;
	logic [15:0] header_crc;

	// traffic shaping knobs
	int          send_idle_pct;
	int          ready_stall_pct;
	int          hold_cycles;
	int          hold_req;
	int          hold_ack;

	// frame being assembled for transmission
	logic [7:0]  pkt_bytes[$];

	crc16_packet_frame_checker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// lsb-first reflected crc-16, fed one data bit at a time
	function automatic logic [15:0] payload_crc_next(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ d[i]) begin
				r = {1'b0, r[15:1]} ^ CRC_POLY;
			end else begin
				r = {1'b0, r[15:1]};
			end
		end
		return r;
	endfunction

	task automatic clear_frame_state();
		seen_count  = 8'd0;
		payload_crc = CRC_START;
		held_type   = 8'd0;
		held_seq    = 8'd0;
		header_crc  = 16'd0;
	endtask

	// advance the frame state by one accepted byte and queue a report on the last one
	task automatic track_frame_byte(input logic [7:0] b, input logic is_last);
		result_t r;
		if (seen_count < FRAME_LIMIT) begin
			case (seen_count)
				8'd0: held_type = b;
				8'd1: held_seq = b;
				8'd2: header_crc[7:0] = b;
				8'd3: header_crc[15:8] = b;
				default: payload_crc = payload_crc_next(payload_crc, b);
			endcase
			seen_count = seen_count + 8'd1;
		end
		if (is_last) begin
			if (seen_count < HEADER_BYTES) begin
				r.status          = ST_SHORT;
				r.packet_type     = 8'd0;
				r.sequence_number = 8'd0;
				r.computed_crc    = 16'd0;
			end else begin
				r.status          = (header_crc == payload_crc) ? ST_OK : ST_BAD_CRC;
				r.packet_type     = held_type;
				r.sequence_number = held_seq;
				r.computed_crc    = payload_crc;
			end
			pending_reports.push_back(r);
			clear_frame_state();
		end
	endtask

	task automatic check_report();
		result_t want;
		if (pending_reports.size() == 0) begin
			$error("report with nothing pending: tuser=%0d tdata=%h", m_tuser, m_tdata);
			mismatches++;
		end else begin
			want = pending_reports.pop_front();
			if (m_tuser !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, m_tuser);
				mismatches++;
			end
			if (m_tdata[7:0] !== want.packet_type) begin
				$error("packet_type: expected %h, got %h", want.packet_type, m_tdata[7:0]);
				mismatches++;
			end
			if (m_tdata[15:8] !== want.sequence_number) begin
				$error("sequence_number: expected %h, got %h",
					want.sequence_number, m_tdata[15:8]);
				mismatches++;
			end
			if (m_tdata[31:16] !== want.computed_crc) begin
				$error("computed_crc: expected %h, got %h", want.computed_crc, m_tdata[31:16]);
				mismatches++;
			end
		end
	endtask

	// receive side: check each report transaction, then pick next cycle's tready
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			check_report();
		end
		if (hold_req != hold_ack) begin
			// long hold-off so the checker backs up and drops s_tready
			hold_ack    <= hold_req;
			hold_cycles <= HOLD_LEN;
			m_tready    <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready    <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// offer one byte, possibly after random idle cycles, and wait for the transaction
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		track_frame_byte(b, is_last);
	endtask

	task automatic send_frame();
		for (int i = 0; i < pkt_bytes.size(); i++) begin
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		end
	endtask

	// put the payload crc into header bytes 2 and 3; bytes past the limit do not count
	task automatic seal_crc();
		logic [15:0] acc;
		acc = CRC_START;
		for (int i = HEADER_BYTES; i < pkt_bytes.size() && i < FRAME_LIMIT; i++) begin
			acc = payload_crc_next(acc, pkt_bytes[i]);
		end
		pkt_bytes[2] = acc[7:0];
		pkt_bytes[3] = acc[15:8];
	endtask

	// header plus random payload; a bad frame keeps its random crc bytes
	task automatic build_frame(input int payload_len, input bit good_crc);
		pkt_bytes.delete();
		for (int i = 0; i < HEADER_BYTES + payload_len; i++) begin
			pkt_bytes.push_back(8'($urandom));
		end
		if (good_crc) begin
			seal_crc();
		end
	endtask

	// sender stops until every owed report has been taken
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		// too short: one, two and three bytes
		pkt_bytes = '{8'hFF};
		send_frame();
		pkt_bytes = '{8'h00, 8'hFF};
		send_frame();
		pkt_bytes = '{8'hA5, 8'h5A, 8'hFF};
		send_frame();
		// header only: empty payload leaves the crc at its start value
		pkt_bytes = '{8'hFF, 8'h00, 8'hFF, 8'hFF};
		send_frame();
		pkt_bytes = '{8'h00, 8'hFF, 8'h00, 8'h00};
		send_frame();
		// short payload with matching crc, then the same frame corrupted
		pkt_bytes = '{8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA};
		seal_crc();
		send_frame();
		pkt_bytes[3] = ~pkt_bytes[3];
		send_frame();
		wait_drained();
	endtask

	// a frame past the byte limit; extra bytes must not reach the crc
	task automatic test_overflow();
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		build_frame(FRAME_LIMIT + 6 - HEADER_BYTES, 1'b1);
		send_frame();
		wait_drained();
	endtask

	// receiver holds off while the sender keeps pushing short frames
	task automatic test_backpressure();
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		hold_req       <= hold_req + 1;
		for (int n = 0; n < 8; n++) begin
			build_frame($urandom_range(4), 1'b1);
			send_frame();
		end
		wait_drained();
	endtask

	task automatic run_traffic_phase(input int idle_pct, input int stall_pct, input int budget);
		int sent;
		int pick;
		int plen;
		send_idle_pct   = idle_pct;
		ready_stall_pct = stall_pct;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(99);
			plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
			if (pick < 60) begin
				build_frame(plen, 1'b1);
			end else if (pick < 80) begin
				build_frame(plen, 1'b0);
			end else if (pick < 92) begin
				// runt frame
				pkt_bytes.delete();
				repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
			end else begin
				// line noise ending in a last byte
				pkt_bytes.delete();
				repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom));
			end
			send_frame();
			sent += pkt_bytes.size();
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(0, 0, 40);
		run_traffic_phase(88, 0, 40);
		run_traffic_phase(0, 88, 40);
		run_traffic_phase(17, 17, 40);
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = 8'd0;
		s_tlast         = 1'b0;
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		clear_frame_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_backpressure();
		test_random_traffic();

		// let the input and result registers drain and catch any stray reports
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_crc16_packet_frame_checker_top: clean");
		end else begin
			$display("tb_crc16_packet_frame_checker_top: errors");
		end
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#10ms;
		$display("tb_crc16_packet_frame_checker_top: errors");
		$finish;
	end

endmodule
